// ----- design/fat_volume_geometry_assert.svh -----
// ----------------------------------------------------------------------------
// fat_volume_geometry_assert.svh
// assertion macros shared by the volume geometry block
// ----------------------------------------------------------------------------
`ifndef FAT_VOLUME_GEOMETRY_ASSERT_SVH
`define FAT_VOLUME_GEOMETRY_ASSERT_SVH

// same-cycle implication, reset masked
`define FVG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fat_volume_geometry: check failed");

// next-cycle implication, reset masked
`define FVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fat_volume_geometry: check failed");

`endif

// ----- design/fvg_pkg.sv -----
// ----------------------------------------------------------------------------
// fvg_pkg
// shared types, status codes and tables of the volume geometry block
// ----------------------------------------------------------------------------
package fvg_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_F16_SMALL = 3'd2,
    ST_F16_LARGE = 3'd3,
    ST_F12_BIG   = 3'd4,
    ST_TOO_SMALL = 3'd5
  } status_e;

  localparam int unsigned F12Limit = 4084;
  localparam int unsigned F16Limit = 65524;

  // item state carried along the pipeline
  typedef struct packed {
    status_e     status;
    logic        fat16;
    logic [7:0]  cs;
    logic [31:0] n;
    logic [32:0] body;
    logic [32:0] fat;
  } item_t;

  // fat16 cluster size from the sector count
  function automatic logic [7:0] f16_cluster(input logic [31:0] n);
    logic [7:0] cs;
    if (n <= 32'd8400)         cs = 8'd0;
    else if (n <= 32'd32680)   cs = 8'd2;
    else if (n <= 32'd262144)  cs = 8'd4;
    else if (n <= 32'd524288)  cs = 8'd8;
    else if (n <= 32'd1048576) cs = 8'd16;
    else if (n <= 32'd2097152) cs = 8'd32;
    else if (n <= 32'd4194304) cs = 8'd64;
    else                       cs = 8'd128;
    return cs;
  endfunction

  // fat12 divisor cs*1024/3 + 2 for legal cluster sizes
  function automatic logic [15:0] f12_divisor(input logic [7:0] cs);
    logic [15:0] d;
    case (cs)
      8'd1:    d = 16'd343;
      8'd2:    d = 16'd684;
      8'd3:    d = 16'd1026;
      8'd4:    d = 16'd1367;
      8'd5:    d = 16'd1708;
      8'd6:    d = 16'd2050;
      8'd7:    d = 16'd2391;
      8'd8:    d = 16'd2732;
      default: d = 16'd2;
    endcase
    return d;
  endfunction

endpackage

// ----- design/fvg_div.sv -----
// ----------------------------------------------------------------------------
// fvg_div
// pipelined restoring divider, one quotient bit per stage, side payload
// ----------------------------------------------------------------------------
module fvg_div #(
  parameter int DW = 33,
  parameter int VW = 16,
  parameter int PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [PW-1:0] payload_i,
  output logic          valid_o,
  output logic [DW-1:0] quotient_o,
  output logic [PW-1:0] payload_o
);

  logic [DW:1]   vld_q;
  logic [DW-1:0] num_q [1:DW];
  logic [DW-1:0] quo_q [1:DW];
  logic [VW-1:0] rem_q [1:DW];
  logic [VW-1:0] dvs_q [1:DW];
  logic [PW-1:0] pay_q [1:DW];

  for (genvar g = 0; g < DW; g++) begin : g_stage
    logic          sv;
    logic [DW-1:0] sn;
    logic [DW-1:0] sq;
    logic [VW-1:0] sr;
    logic [VW-1:0] sd;
    logic [PW-1:0] sp;
    logic [VW:0]   trial;
    logic          ge;

    // stage source: ports for the first stage, registers after
    if (g == 0) begin : g_first
      assign sv = valid_i;
      assign sn = dividend_i;
      assign sq = '0;
      assign sr = '0;
      assign sd = divisor_i;
      assign sp = payload_i;
    end else begin : g_next
      assign sv = vld_q[g];
      assign sn = num_q[g];
      assign sq = quo_q[g];
      assign sr = rem_q[g];
      assign sd = dvs_q[g];
      assign sp = pay_q[g];
    end

    // one trial subtract
    assign trial = {sr, sn[DW-1]};
    assign ge    = trial >= {1'b0, sd};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= sv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[g+1] <= {sn[DW-2:0], 1'b0};
        quo_q[g+1] <= {sq[DW-2:0], ge};
        rem_q[g+1] <= ge ? VW'(trial - {1'b0, sd}) : trial[VW-1:0];
        dvs_q[g+1] <= sd;
        pay_q[g+1] <= sp;
      end
    end
  end

  assign valid_o    = vld_q[DW];
  assign quotient_o = quo_q[DW];
  assign payload_o  = pay_q[DW];

endmodule

// ----- design/fat_volume_geometry.sv -----
// ----------------------------------------------------------------------------
// fat_volume_geometry
// fat12/fat16 volume layout: cluster size, fat size, clusters, data start
// ----------------------------------------------------------------------------
// path: stage a, stage b, fat divider, stage c, cluster divider, output reg
// throughput: one item per cycle unless stalled; 33-stage dividers set depth
// stalls on the output freeze the whole pipeline, nothing is dropped
// reset: pipeline emptied, start cluster register returns to 4
// ----------------------------------------------------------------------------
module fat_volume_geometry #(
  parameter int ROOT_ENTRIES = 512
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write: fat12 start cluster
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i,
  // input stream
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [31:0]  s_tdata_i,   // [31:0] sector_count
  input  logic [15:0]  s_tuser_i,   // [15:0] type_code
  // result stream
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [111:0] m_tdata_o,   // status, cluster_sectors, fat_sectors,
                                    // cluster_total, data_start, small_total,
                                    // wide_total, zero pad
  output logic         m_tuser_o    // [0] is_fat16
);

  import fvg_pkg::*;
  `include "fat_volume_geometry_assert.svh"

  localparam int RootSec  = ROOT_ENTRIES / 16;
  localparam int ItemW    = $bits(item_t);
  localparam int F12Fixed = 1 + 24 + RootSec;

  logic        en;
  logic [7:0]  start_q;
  logic        out_vld_q;
  logic [111:0] out_data_q;
  logic        out_user_q;

  assign en          = !out_vld_q || m_tready_i;
  assign s_tready_o  = en;
  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 8'd4;
    end else if (cfg_valid_i) begin
      start_q <= cfg_data_i;
    end
  end

  // stage a: type decode and cluster size choice
  logic  a_vld_q;
  item_t a_d, a_q;
  logic  t16, t12;
  logic [7:0] f12_start;
  logic [6:0] f12_go;
  logic [2:0] f12_steps;
  logic [7:0] f12_cs;

  assign t16 = s_tuser_i == 16'h0400 || s_tuser_i == 16'h0600 || s_tuser_i == 16'h0E00 ||
               s_tuser_i == 16'h1E00 || s_tuser_i == 16'h1400 || s_tuser_i == 16'h1600;
  assign t12 = s_tuser_i == 16'h0100 || s_tuser_i == 16'h1100;

  always_comb begin
    f12_start = (start_q == 8'd0) ? 8'd1 : start_q;
    f12_steps = 3'd0;
    // doubling search, all seven candidate sizes checked side by side;
    // the checks fail from the first failing size on, so the count of
    // passing sizes is the number of doublings
    for (int k = 0; k < 7; k++) begin
      f12_go[k] = ((15'(f12_start) << k) < 15'd64) &&
                  !((33'(F12Fixed) + 33'(15'(f12_start) << k) * 33'(F12Limit)) >
                    {1'b0, s_tdata_i});
      if (f12_go[k]) begin
        f12_steps = f12_steps + 3'd1;
      end
    end
    f12_cs     = f12_start << f12_steps;
    a_d        = '0;
    a_d.n      = s_tdata_i;
    a_d.fat16  = t16;
    a_d.cs     = t16 ? f16_cluster(s_tdata_i) : f12_cs;
    a_d.status = (t16 || t12) ? ST_OK : ST_BAD_TYPE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
    end
  end

  // stage b: early checks, body size and fat division operands
  logic        b_vld_q;
  item_t       b_d, b_q;
  logic [32:0] b_num_d, b_num_q;
  logic [15:0] b_dvs_d, b_dvs_q;

  always_comb begin
    b_d      = a_q;
    b_d.body = {1'b0, a_q.n} - 33'(RootSec + 1);
    if (a_q.status == ST_OK) begin
      if (a_q.fat16 && a_q.cs == 8'd0) begin
        b_d.status = ST_F16_SMALL;
      end else if (!a_q.fat16 && a_q.cs > 8'd8) begin
        b_d.status = ST_F12_BIG;
      end else if ({1'b0, a_q.n} < 33'(RootSec + 1)) begin
        b_d.status = ST_TOO_SMALL;
      end
    end
    if (a_q.fat16) begin
      b_num_d = b_d.body + {17'd0, a_q.cs, 8'd1};
      b_dvs_d = {a_q.cs, 8'd2};
    end else begin
      b_num_d = b_d.body + {24'd0, a_q.cs, 1'b0};
      b_dvs_d = f12_divisor(a_q.cs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q     <= b_d;
      b_num_q <= b_num_d;
      b_dvs_q <= b_dvs_d;
    end
  end

  // fat size division
  logic             q1_vld;
  logic [32:0]      q1;
  logic [ItemW-1:0] q1_pay;

  fvg_div #(.DW(33), .VW(16), .PW(ItemW)) u_div_fat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (b_vld_q),
    .dividend_i (b_num_q),
    .divisor_i  (b_dvs_q),
    .payload_i  (ItemW'(b_q)),
    .valid_o    (q1_vld),
    .quotient_o (q1),
    .payload_o  (q1_pay)
  );

  // stage c: fat size, fit check, cluster division operand
  logic        c_vld_q;
  item_t       c_d, c_q;
  logic [32:0] c_rem_d, c_rem_q;
  logic [33:0] two_fat;

  always_comb begin
    c_d     = item_t'(q1_pay);
    c_d.fat = q1 + {32'd0, !c_d.fat16};
    two_fat = {c_d.fat, 1'b0};
    c_rem_d = c_d.body - two_fat[32:0];
    if (c_d.status == ST_OK && two_fat > {1'b0, c_d.body}) begin
      c_d.status = ST_TOO_SMALL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= q1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q     <= c_d;
      c_rem_q <= c_rem_d;
    end
  end

  // cluster count division
  logic             q2_vld;
  logic [32:0]      q2;
  logic [ItemW-1:0] q2_pay;

  fvg_div #(.DW(33), .VW(8), .PW(ItemW)) u_div_clus (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (c_vld_q),
    .dividend_i (c_rem_q),
    .divisor_i  (c_q.cs),
    .payload_i  (ItemW'(c_q)),
    .valid_o    (q2_vld),
    .quotient_o (q2),
    .payload_o  (q2_pay)
  );

  // stage d: final checks, saturation and result packing
  item_t       d_it;
  status_e     d_st;
  logic [34:0] d_ds;
  logic [34:0] d_tot;
  logic [15:0] d_fat, d_clus;
  logic [17:0] d_ds_sat;
  logic [111:0] d_data;

  always_comb begin
    d_it  = item_t'(q2_pay);
    d_st  = d_it.status;
    d_ds  = 35'd1 + {1'b0, d_it.fat, 1'b0} + 35'(RootSec);
    d_tot = d_ds + {27'd0, d_it.cs};
    if (d_st == ST_OK) begin
      if (d_it.fat16 && (d_it.cs == 8'd128 || q2 > 33'(F16Limit))) begin
        d_st = ST_F16_LARGE;
      end else if (d_tot > {3'd0, d_it.n}) begin
        d_st = ST_TOO_SMALL;
      end
    end
    d_fat    = (d_it.fat > 33'hFFFF) ? 16'hFFFF : d_it.fat[15:0];
    d_clus   = (q2 > 33'hFFFF) ? 16'hFFFF : q2[15:0];
    d_ds_sat = (d_ds > 35'h3FFFF) ? 18'h3FFFF : d_ds[17:0];
    d_data   = '0;
    d_data[2:0] = d_st;
    if (d_st == ST_OK) begin
      d_data[10:3]  = d_it.cs;
      d_data[26:11] = d_fat;
      d_data[42:27] = d_clus;
      d_data[60:43] = d_ds_sat;
      d_data[76:61] = (d_it.n[31:16] == 16'd0) ? d_it.n[15:0] : 16'd0;
      d_data[108:77] = (d_it.n[31:16] == 16'd0) ? 32'd0 : d_it.n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= q2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= d_data;
      out_user_q <= (d_st == ST_OK) && d_it.fat16;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

  // error results carry nothing but the status
  `FVG_ASSERT_NOW(a_err_zero, m_tvalid_o && m_tdata_o[2:0] != ST_OK,
                  m_tdata_o[111:3] == '0 && !m_tuser_o)
  // a good result always has a cluster size
  `FVG_ASSERT_NOW(a_ok_cs, m_tvalid_o && m_tdata_o[2:0] == ST_OK, m_tdata_o[10:3] != 8'd0)
  // a held result stays put while stalled
  `FVG_ASSERT_NEXT(a_hold, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o))

endmodule

// ----- tb/fat_volume_geometry_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_volume_geometry_chk
// watches the config, input and result channels of the volume geometry
// block, predicts each layout from the request and compares in order
// ----------------------------------------------------------------------------
module fat_volume_geometry_chk (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [7:0]   cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [31:0]  s_tdata_i,
  input  logic [15:0]  s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [111:0] m_tdata_i,
  input  logic         m_tuser_i,
  output int           pending_o,
  output int           errors_o
);

  import fvg_pkg::*;

  localparam int unsigned RootSecs = 512 / 16;

  typedef struct packed {
    status_e     status;
    logic        fat16;
    logic [7:0]  cs;
    logic [15:0] fat;
    logic [15:0] clus;
    logic [17:0] ds;
    logic [15:0] small_tot;
    logic [31:0] big_tot;
  } layout_t;

  layout_t     layouts_due[$];
  logic [7:0]  start_cs;

  function automatic layout_t error_layout(input status_e st);
    layout_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // geometry of one format request
  function automatic layout_t volume_layout(input logic [31:0] n, input logic [15:0] t,
                                            input logic [7:0] start);
    layout_t r;
    longint unsigned body, fat, clus, ds, cs, dv;
    r = '0;
    if (t == 16'h0400 || t == 16'h0600 || t == 16'h0e00 || t == 16'h1e00 ||
        t == 16'h1400 || t == 16'h1600) begin
      r.fat16 = 1'b1;
      if (n <= 8400) return error_layout(ST_F16_SMALL);
      else if (n <= 32680) cs = 2;
      else if (n <= 262144) cs = 4;
      else if (n <= 524288) cs = 8;
      else if (n <= 1048576) cs = 16;
      else if (n <= 2097152) cs = 32;
      else if (n <= 4194304) cs = 64;
      else cs = 128;
      if (n < RootSecs + 1) return error_layout(ST_TOO_SMALL);
      body = n - RootSecs - 1;
      dv = cs * 256 + 2;
      fat = (body + dv - 1) / dv;
      if (2 * fat > body) return error_layout(ST_TOO_SMALL);
      clus = (body - 2 * fat) / cs;
      if (cs == 128 || clus > 65524) return error_layout(ST_F16_LARGE);
    end else if (t == 16'h0100 || t == 16'h1100) begin
      // double the cluster until 4084 clusters cover the partition
      cs = (start == 0) ? 1 : start;
      while (cs < 64) begin
        if (1 + 24 + RootSecs + cs * 4084 > n) break;
        cs = cs * 2;
      end
      if (cs > 8) return error_layout(ST_F12_BIG);
      if (n < RootSecs + 1) return error_layout(ST_TOO_SMALL);
      body = n - RootSecs - 1;
      fat = (body + 2 * cs) / (cs * 1024 / 3 + 2) + 1;
      if (2 * fat > body) return error_layout(ST_TOO_SMALL);
      clus = (body - 2 * fat) / cs;
    end else begin
      return error_layout(ST_BAD_TYPE);
    end
    if (1 + 2 * fat + RootSecs + cs > n) return error_layout(ST_TOO_SMALL);
    ds = 1 + 2 * fat + RootSecs;
    r.status    = ST_OK;
    r.cs        = cs[7:0];
    r.fat       = (fat > 65535) ? 16'hffff : fat[15:0];
    r.clus      = (clus > 65535) ? 16'hffff : clus[15:0];
    r.ds        = (ds > 18'h3ffff) ? 18'h3ffff : ds[17:0];
    r.small_tot = (n < 65536) ? n[15:0] : 16'd0;
    r.big_tot   = (n < 65536) ? 32'd0 : n;
    return r;
  endfunction

  assign pending_o = layouts_due.size();

  // register copy, predictions and in-order comparison
  always @(posedge clk_i or negedge rst_ni) begin
    layout_t want, got;
    if (!rst_ni) begin
      start_cs = 8'd4;
      layouts_due.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) start_cs = cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        layouts_due.push_back(volume_layout(s_tdata_i, s_tuser_i, start_cs));
      if (m_tvalid_i && m_tready_i) begin
        got.status    = status_e'(m_tdata_i[2:0]);
        got.fat16     = m_tuser_i;
        got.cs        = m_tdata_i[10:3];
        got.fat       = m_tdata_i[26:11];
        got.clus      = m_tdata_i[42:27];
        got.ds        = m_tdata_i[60:43];
        got.small_tot = m_tdata_i[76:61];
        got.big_tot   = m_tdata_i[108:77];
        if (layouts_due.size() == 0) begin
          errors_o = errors_o + 1;
          if (errors_o <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = layouts_due.pop_front();
          if (got !== want || m_tdata_i[111:109] !== 3'b000) begin
            errors_o = errors_o + 1;
            if (errors_o <= 10)
              $display("layout mismatch\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
    end
  end

endmodule

// ----- tb/fat_volume_geometry_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_volume_geometry_tb
// drives format requests in random bursts under a stalling receiver across
// several fat12 start cluster settings; the checker predicts and compares
// ----------------------------------------------------------------------------
module fat_volume_geometry_tb;
  import fvg_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_data_i = '0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [31:0]  s_tdata_i = '0;
  logic [15:0]  s_tuser_i = '0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [111:0] m_tdata_o;
  logic         m_tuser_o;
  int           pending, errors;
  int           burst_left = 0;
  logic [15:0]  stall_pat = 16'hffff;

  localparam logic [15:0] TypeF16A = 16'h0400, TypeF16B = 16'h0600, TypeF16C = 16'h0e00;
  localparam logic [15:0] TypeF16D = 16'h1e00, TypeF16E = 16'h1400, TypeF16F = 16'h1600;
  localparam logic [15:0] TypeF12A = 16'h0100, TypeF12B = 16'h1100;

  logic [15:0] known_types [8] = '{TypeF16A, TypeF16B, TypeF16C, TypeF16D,
                                   TypeF16E, TypeF16F, TypeF12A, TypeF12B};
  logic [7:0]  start_settings [8] = '{8'd1, 8'd0, 8'd128, 8'd255, 8'd3, 8'd8, 8'd2, 8'd4};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  fat_volume_geometry dut (.*);

  fat_volume_geometry_chk chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i, .s_tuser_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o), .m_tuser_i(m_tuser_o),
    .pending_o(pending), .errors_o(errors)
  );

  // receiver stall pattern, reloaded now and then, sometimes never stalling
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0)
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
    else
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    m_tready_i <= stall_pat[0];
  end

  // one request transfer, with burst gaps in front
  task automatic send_request(input logic [31:0] n, input logic [15:0] t);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= n;
    s_tuser_i  <= t;
    do @(negedge clk_i); while (!s_tready_o);
    @(posedge clk_i);
    if (burst_left == 0) s_tvalid_i <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_start_cluster(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 300);
      1:       return $urandom_range(0, 70000);
      2:       return $urandom_range(8000, 40000);
      3:       return $urandom_range(200000, 5000000);
      4:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [15:0] t;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edges of the fat16 table, root size and fat12 search, unknown types
    send_request(32'd0, TypeF16A);
    send_request(32'd0, TypeF12A);
    send_request(32'd32, TypeF12B);
    send_request(32'd33, TypeF12A);
    send_request(32'd40, TypeF12A);
    send_request(32'd8400, TypeF16B);
    send_request(32'd8401, TypeF16C);
    send_request(32'd32680, TypeF16D);
    send_request(32'd32681, TypeF16E);
    send_request(32'd65535, TypeF16F);
    send_request(32'd65536, TypeF16A);
    send_request(32'd262144, TypeF16A);
    send_request(32'd524289, TypeF16B);
    send_request(32'd2097152, TypeF16C);
    send_request(32'd4194304, TypeF16D);
    send_request(32'd4194305, TypeF16E);
    send_request(32'hffffffff, TypeF16F);
    send_request(32'hffffffff, TypeF12B);
    send_request(32'd16393, TypeF12A);
    send_request(32'd16394, TypeF12A);
    send_request(32'd40000, TypeF12B);
    send_request(32'd100000, 16'h0000);
    send_request(32'd100000, 16'hffff);
    send_request(32'd100000, 16'h0401);

    for (int ph = 0; ph <= 8; ph++) begin
      if (ph > 0) begin
        drain();
        write_start_cluster(start_settings[ph - 1]);
      end
      for (int i = 0; i < 155; i++) begin
        t = ($urandom_range(0, 9) < 7) ? known_types[$urandom_range(0, 7)] : 16'($urandom);
        send_request(pick_count(), t);
      end
    end
    drain();

    if (errors == 0) begin
      $display("fat_volume_geometry_tb: done, clean");
    end else begin
      $display("fat_volume_geometry_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("fat_volume_geometry_tb: done, errors");
    $finish;
  end

endmodule
